// ----- hdl/irsq_pkg.sv -----
// Shared widths, constants and the seed table of the reciprocal square root pipeline.
package irsq_pkg;

    localparam int OPER_W = 31;  // operand and result width, 15.16 unsigned
    localparam int FRAC_W = 16;  // fraction bits of the 15.16 format
    localparam int X_W    = 25;  // estimate width, bounded by 1/sqrt of the smallest operand
    localparam int AX_W   = 26;  // a*x in 10.16
    localparam int AXX_W  = 19;  // a*x*x in 3.16
    localparam int TERM_W = 18;  // 3 - a*x*x in 2.16, always positive
    localparam int SEED_W = 16;
    localparam int IDX_W  = 3;
    localparam int SH_W   = 3;
    localparam int POS_W  = 5;

    localparam logic [OPER_W-1:0] SAT_VALUE  = 31'h7fffffff;
    localparam logic [OPER_W-1:0] SMALL_MASK = 31'h7ffffffc;
    localparam logic [SEED_W-1:0] INV_SQRT2  = 16'hb504;
    localparam logic [AXX_W-1:0]  THREE_Q16  = 19'h30000;
    localparam logic [IDX_W-1:0]  IDX_MASK   = 3'h7;

    // 1/(2*sqrt(m)) for m = 0.5 + idx/16, in 0.16
    function automatic logic [SEED_W-1:0] seed_lut(input logic [IDX_W-1:0] idx);
        logic [SEED_W-1:0] seed;
        case (idx)
            3'd0: seed = 16'hb504;
            3'd1: seed = 16'haaaa;
            3'd2: seed = 16'ha1e8;
            3'd3: seed = 16'h9a5f;
            3'd4: seed = 16'h93cd;
            3'd5: seed = 16'h8e00;
            3'd6: seed = 16'h88d6;
            3'd7: seed = 16'h8432;
            default: seed = 16'hb504;
        endcase
        return seed;
    endfunction

endpackage

// ----- hdl/irsq_newton.sv -----
// One Newton-Raphson refinement step for the reciprocal square root, three register stages.
module irsq_newton (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [irsq_pkg::OPER_W-1:0] i_a,
    input  logic [irsq_pkg::X_W-1:0]    i_x,
    input  logic                       i_sat,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [irsq_pkg::OPER_W-1:0] o_a,
    output logic [irsq_pkg::X_W-1:0]    o_x,
    output logic                       o_sat
);
    import irsq_pkg::*;

    // Stage A: a*x
    logic                 r_vld_a;
    logic [AX_W-1:0]      r_ax;
    logic [X_W-1:0]       r_x_a;
    logic [OPER_W-1:0]    r_a_a;
    logic                 r_sat_a;
    // Stage B: a*x*x
    logic                 r_vld_b;
    logic [AXX_W-1:0]     r_axx;
    logic [X_W-1:0]       r_x_b;
    logic [OPER_W-1:0]    r_a_b;
    logic                 r_sat_b;
    // Stage C: (x/2)*(3 - a*x*x)
    logic                 r_vld_c;
    logic [X_W-1:0]       r_x_c;
    logic [OPER_W-1:0]    r_a_c;
    logic                 r_sat_c;

    logic                        rdy_a, rdy_b, rdy_c;
    logic [OPER_W+X_W-1:0]       prod_ax;
    logic [AX_W+X_W-1:0]         prod_axx;
    logic [AXX_W-1:0]            diff;
    logic [TERM_W-1:0]           term;
    logic [X_W-1+TERM_W-1:0]     prod_xn;

    // A stage loads whenever it is empty or the stage after it moves on.
    assign rdy_c   = !r_vld_c || !i_stall;
    assign rdy_b   = !r_vld_b || rdy_c;
    assign rdy_a   = !r_vld_a || rdy_b;
    assign o_stall = !rdy_a;

    assign prod_ax  = i_a * i_x;
    assign prod_axx = r_ax * r_x_a;
    assign diff     = THREE_Q16 - r_axx;
    assign term     = diff[TERM_W-1:0];
    assign prod_xn  = r_x_b[X_W-1:1] * term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_vld_a <= i_valid;
            end
            if (rdy_b) begin
                r_vld_b <= r_vld_a;
            end
            if (rdy_c) begin
                r_vld_c <= r_vld_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_ax    <= prod_ax[FRAC_W +: AX_W];
            r_x_a   <= i_x;
            r_a_a   <= i_a;
            r_sat_a <= i_sat;
        end
        if (rdy_b) begin
            r_axx   <= prod_axx[FRAC_W +: AXX_W];
            r_x_b   <= r_x_a;
            r_a_b   <= r_a_a;
            r_sat_b <= r_sat_a;
        end
        if (rdy_c) begin
            r_x_c   <= prod_xn[FRAC_W +: X_W];
            r_a_c   <= r_a_b;
            r_sat_c <= r_sat_b;
        end
    end

    assign o_valid = r_vld_c;
    assign o_x     = r_x_c;
    assign o_a     = r_a_c;
    assign o_sat   = r_sat_c;

endmodule

// ----- hdl/fixed_point_inverse_square_root.sv -----
// Throughput: one word per cycle unless the output stalls; every stage has its own valid bit
// and loads whenever it is empty or its successor moves, so bubbles are squeezed out while the
// output is stalled.
// The depth is set by two seed stages, two three-stage Newton-Raphson steps and the output stage.
// Reset (synchronous, active low) clears every valid bit; the datapath registers are not reset.
module fixed_point_inverse_square_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [irsq_pkg::OPER_W-1:0] i_operand,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [irsq_pkg::OPER_W-1:0] o_recip_root
);
    import irsq_pkg::*;

    // The exponent e of the operand is 15 minus the position of its leading one. Positions at
    // or above this bound give e <= 0 and a right shift of the seed; lower ones a left shift.
    localparam logic [POS_W-1:0] POS_UNITY = 5'd15;
    localparam logic [POS_W-1:0] POS_LEFT  = 5'd16;

    // Stage 1: leading-one search, table index and seed lookup.
    logic [POS_W-1:0]      lead_pos;
    logic [OPER_W+2:0]     idx_src;
    logic [IDX_W-1:0]      idx;
    logic [POS_W-1:0]      sh_full;
    logic                  sh_left;

    logic                  r_vld_1;
    logic [SEED_W-1:0]     r_seed_1;
    logic [SH_W-1:0]       r_sh_1;
    logic                  r_left_1;
    logic                  r_odd_1;
    logic [OPER_W-1:0]     r_a_1;
    logic                  r_sat_1;

    // Stage 2: exponent shift and the odd-exponent scaling by 1/sqrt(2).
    logic [X_W-1:0]        seed_x;
    logic [X_W-1:0]        shifted;
    logic [X_W+SEED_W-1:0] prod_odd;
    logic [X_W-1:0]        n_x_2;

    logic                  r_vld_2;
    logic [X_W-1:0]        r_x_2;
    logic [OPER_W-1:0]     r_a_2;
    logic                  r_sat_2;

    // Newton-Raphson steps
    logic                  n1_stall, n1_vld, n1_sat;
    logic [OPER_W-1:0]     n1_a;
    logic [X_W-1:0]        n1_x;
    logic                  n2_stall, n2_vld, n2_sat;
    logic [OPER_W-1:0]     n2_a;
    logic [X_W-1:0]        n2_x;

    // Output stage
    logic                  r_vld_o;
    logic [OPER_W-1:0]     r_root_o;

    logic                  rdy_1, rdy_2, rdy_o;

    // Ready chain, from the output back to the input.
    assign rdy_o   = !r_vld_o || !i_stall;
    assign rdy_2   = !r_vld_2 || !n1_stall;
    assign rdy_1   = !r_vld_1 || rdy_2;
    assign o_stall = !rdy_1;

    // The highest set bit wins; the loop simply overwrites lower hits.
    always_comb begin
        lead_pos = '0;
        for (int i = 0; i < OPER_W; i++) begin
            if (i_operand[i]) begin
                lead_pos = POS_W'(i);
            end
        end
    end

    // The three bits below the leading one. With three zeros appended, an operand whose
    // leading one sits at bit 2 takes its index with a zero filled in at the bottom.
    assign idx_src = {i_operand, 3'b000} >> lead_pos;
    assign idx     = idx_src[IDX_W-1:0] & IDX_MASK;

    // Right shift by -e/2 for e <= 0, left shift by ceil(e/2) for e > 0. For operands that
    // saturate the position is meaningless and so is the shift.
    always_comb begin
        if (lead_pos >= POS_UNITY) begin
            sh_left = 1'b0;
            sh_full = lead_pos - POS_UNITY;
        end else begin
            sh_left = 1'b1;
            sh_full = POS_LEFT - lead_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_1 <= 1'b0;
            r_vld_2 <= 1'b0;
            r_vld_o <= 1'b0;
        end else begin
            if (rdy_1) begin
                r_vld_1 <= i_valid;
            end
            if (rdy_2) begin
                r_vld_2 <= r_vld_1;
            end
            if (rdy_o) begin
                r_vld_o <= n2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_1) begin
            r_seed_1 <= seed_lut(idx);
            r_sh_1   <= sh_full[SH_W:1];
            r_left_1 <= sh_left;
            r_odd_1  <= ~lead_pos[0];   // e is odd exactly when the position is even
            r_a_1    <= i_operand;
            r_sat_1  <= (i_operand & SMALL_MASK) == '0;
        end
    end

    // The doubled seed is at most 17 bits and a shift of seven keeps it inside the estimate.
    assign seed_x   = X_W'({r_seed_1, 1'b0});
    assign shifted  = r_left_1 ? (seed_x << r_sh_1) : (seed_x >> r_sh_1);
    assign prod_odd = shifted * INV_SQRT2;
    assign n_x_2    = r_odd_1 ? prod_odd[FRAC_W +: X_W] : shifted;

    always_ff @(posedge i_clk) begin
        if (rdy_2) begin
            r_x_2   <= n_x_2;
            r_a_2   <= r_a_1;
            r_sat_2 <= r_sat_1;
        end
    end

    irsq_newton u_step1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_2),
        .o_stall (n1_stall),
        .i_a     (r_a_2),
        .i_x     (r_x_2),
        .i_sat   (r_sat_2),
        .o_valid (n1_vld),
        .i_stall (n2_stall),
        .o_a     (n1_a),
        .o_x     (n1_x),
        .o_sat   (n1_sat)
    );

    irsq_newton u_step2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (n1_vld),
        .o_stall (n2_stall),
        .i_a     (n1_a),
        .i_x     (n1_x),
        .i_sat   (n1_sat),
        .o_valid (n2_vld),
        .i_stall (!rdy_o),
        .o_a     (n2_a),
        .o_x     (n2_x),
        .o_sat   (n2_sat)
    );

    // Operands below four (and zero) give the saturated value instead of the estimate. The
    // operand itself is no longer needed after the second step.
    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_root_o <= (n2_sat || (n2_a == '0)) ? SAT_VALUE : OPER_W'(n2_x);
        end
    end

    assign o_valid      = r_vld_o;
    assign o_recip_root = r_root_o;

endmodule

// ----- hdl/irsq_checker.sv -----
// Port-level checks for the reciprocal square root pipeline and their binding.
module irsq_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic [irsq_pkg::OPER_W-1:0] i_operand,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [irsq_pkg::OPER_W-1:0] o_recip_root
);
    // The pipeline only pushes back once every stage, the output included, is full and stalled.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output side was free");

    // No result can appear in the cycle after a reset.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present straight after reset");

    // A free output side means the input side is free as well.
    a_free_out_free_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled although the output was not");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_recip_root)))
        else $error("stalled result word changed or vanished");

    // An operand word that is held off stays on offer unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_operand)))
        else $error("stalled operand word changed or was withdrawn");

endmodule

bind fixed_point_inverse_square_root irsq_checker u_irsq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_operand    (i_operand),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_recip_root (o_recip_root)
);
